// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define CHK_IMPLIES(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("check failed");

`define CHK_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("check failed");

`endif

// ===== sv/crdsa_pkg.sv =====
// ----------------------------------------------------------------------------
// crdsa_pkg
// Types and constants for the interference canceller.
// ----------------------------------------------------------------------------
`default_nettype none
package crdsa_pkg;
	localparam int NumSlots     = 32;
	localparam int SlotCapacity = 8;
	localparam int IdBits       = 16;
	localparam int SlotW = $clog2(NumSlots);
	localparam int CapW  = $clog2(SlotCapacity);
	localparam int FillW = $clog2(SlotCapacity + 1);
	localparam int CntW  = $clog2(NumSlots + 1);
	localparam int AddrW = SlotW + CapW;
	localparam int StoreDepth = NumSlots * SlotCapacity;

	localparam logic OP_ADD = 1'b0;
	localparam logic OP_EOF = 1'b1;
	localparam logic KIND_PKT = 1'b0;
	localparam logic KIND_SUM = 1'b1;

	typedef struct packed {
		logic        operation;
		logic [4:0]  slot_index;
		logic [15:0] packet_id;
	} in_item_t;

	typedef struct packed {
		logic        kind;
		logic [15:0] packet_id_res;
		logic [4:0]  decoded_slot;
		logic [5:0]  collision_count;
		logic        last;
	} out_item_t;
endpackage
`default_nettype wire

// ===== sv/crdsa_interference_cancel.sv =====
// ----------------------------------------------------------------------------
// crdsa_interference_cancel
// Successive interference cancellation over one frame of replica slots.
// ----------------------------------------------------------------------------
// End of frame runs sweeps over all slots; each replica is read from the slot
// RAM and compared against the decoded list, one decoded entry per cycle,
// through a single shared comparator, so a frame's decode time grows with
// replicas times decoded ids times sweeps. The block is not ready during
// decode or while results are emitted; results leave through a one-entry
// output register.
`default_nettype none
module crdsa_interference_cancel
	import crdsa_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	input  wire in_item_t  in_data,
	output logic           out_valid,
	input  wire logic      out_ready,
	output out_item_t      out_data
);
	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_SLOT  = 9'b000000010,
		S_RD    = 9'b000000100,
		S_CMP   = 9'b000001000,
		S_WB    = 9'b000010000,
		S_DONE  = 9'b000100000,
		S_EMIT  = 9'b001000000,
		S_SUM   = 9'b010000000,
		S_CLR   = 9'b100000000
	} state_t;

	state_t state_q;
	logic [FillW-1:0] fill_q [NumSlots];
	logic [NumSlots-1:0] ovf_q;
	logic [SlotW-1:0] slot_q;
	logic [CapW-1:0] r_q;
	logic [FillW-1:0] w_q;
	logic [CntW-1:0] k_q;
	logic [CntW-1:0] total_q;
	logic [CntW-1:0] cnt_q;
	logic progress_q;
	logic hit_q;
	logic [IdBits-1:0] cur_q;
	logic [IdBits-1:0] surv_q;
	logic [SlotW-1:0] from_q [NumSlots];

	logic st_we;
	logic [AddrW-1:0] st_waddr, st_raddr;
	logic [IdBits-1:0] st_wdata, st_rdata;
	logic dec_we;
	logic [SlotW-1:0] dec_waddr, dec_raddr;
	logic [IdBits-1:0] dec_rdata;

	crdsa_ram #(.Width(IdBits), .Depth(StoreDepth)) u_store (
		.clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
		.raddr(st_raddr), .rdata(st_rdata)
	);
	crdsa_ram #(.Width(IdBits), .Depth(NumSlots)) u_dec (
		.clk(clk), .we(dec_we), .waddr(dec_waddr), .wdata(surv_q),
		.raddr(dec_raddr), .rdata(dec_rdata)
	);

	logic in_xfer;
	logic slot_ok;
	logic [FillW-1:0] fill_cur;
	logic out_free;
	logic out_load;
	assign in_xfer  = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE) && !out_valid;
	assign slot_ok  = {1'b0, in_data.slot_index} < (SlotW + 1)'(NumSlots);
	assign fill_cur = fill_q[slot_q];
	assign out_free = !out_valid || out_ready;
	assign out_load = out_free && (((state_q == S_EMIT) && (k_q != total_q) && hit_q) ||
		(state_q == S_CLR));

	always_comb begin
		st_we    = 1'b0;
		st_waddr = {in_data.slot_index[SlotW-1:0],
			fill_q[in_data.slot_index[SlotW-1:0]][CapW-1:0]};
		st_wdata = in_data.packet_id[IdBits-1:0];
		if (in_xfer && in_data.operation == OP_ADD && slot_ok &&
				fill_q[in_data.slot_index[SlotW-1:0]] < FillW'(SlotCapacity)) begin
			st_we = 1'b1;
		end
		if (state_q == S_WB && !hit_q) begin
			st_we    = 1'b1;
			st_waddr = {slot_q, w_q[CapW-1:0]};
			st_wdata = cur_q;
		end
		st_raddr = {slot_q, r_q};
		dec_we    = (state_q == S_DONE) && (fill_cur == FillW'(1)) &&
			(total_q < CntW'(NumSlots));
		dec_waddr = total_q[SlotW-1:0];
		dec_raddr = k_q[SlotW-1:0];
	end

	always_ff @(posedge clk) begin
		if (dec_we) begin
			from_q[total_q[SlotW-1:0]] <= slot_q;
		end
		if (state_q == S_CMP && k_q == '0) begin
			cur_q <= st_rdata;
		end
		if (state_q == S_WB && !hit_q && w_q == '0) begin
			surv_q <= cur_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			ovf_q      <= '0;
			slot_q     <= '0;
			r_q        <= '0;
			w_q        <= '0;
			k_q        <= '0;
			total_q    <= '0;
			cnt_q      <= '0;
			progress_q <= 1'b0;
			hit_q      <= 1'b0;
			out_valid  <= 1'b0;
			out_data   <= '0;
			for (int i = 0; i < NumSlots; i++) begin
				fill_q[i] <= '0;
			end
		end else begin
			if (out_valid && out_ready && !out_load) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						if (in_data.operation == OP_ADD) begin
							if (slot_ok) begin
								if (fill_q[in_data.slot_index[SlotW-1:0]] <
										FillW'(SlotCapacity)) begin
									fill_q[in_data.slot_index[SlotW-1:0]] <=
										fill_q[in_data.slot_index[SlotW-1:0]] + 1'b1;
								end else begin
									ovf_q[in_data.slot_index[SlotW-1:0]] <= 1'b1;
								end
							end
						end else begin
							total_q    <= '0;
							slot_q     <= '0;
							progress_q <= 1'b0;
							state_q    <= S_SLOT;
						end
					end
				end
				S_SLOT: begin
					r_q <= '0;
					w_q <= '0;
					if (ovf_q[slot_q] || fill_cur == '0) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_RD;
					end
				end
				S_RD: begin
					k_q     <= '0;
					hit_q   <= 1'b0;
					state_q <= S_CMP;
				end
				S_CMP: begin
					// one decoded id per cycle; RAM data is registered, so it belongs to the previous k
					if (k_q != '0 && dec_rdata == cur_q) begin
						hit_q <= 1'b1;
					end
					if (k_q == total_q) begin
						state_q <= S_WB;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				S_WB: begin
					if (!hit_q) begin
						w_q <= w_q + 1'b1;
					end
					if ({1'b0, r_q} + 1'b1 == FillW'(fill_cur)) begin
						fill_q[slot_q] <= hit_q ? w_q : w_q + 1'b1;
						state_q <= S_DONE;
						r_q <= '0;
					end else begin
						r_q <= r_q + 1'b1;
						state_q <= S_RD;
					end
				end
				S_DONE: begin
					if (dec_we) begin
						total_q <= total_q + 1'b1;
					end
					if (slot_q == SlotW'(NumSlots - 1)) begin
						slot_q <= '0;
						if (progress_q || dec_we) begin
							progress_q <= 1'b0;
							state_q    <= S_SLOT;
						end else begin
							k_q     <= '0;
							cnt_q   <= '0;
							hit_q   <= 1'b0;
							state_q <= S_EMIT;
						end
					end else begin
						if (dec_we) begin
							progress_q <= 1'b1;
						end
						slot_q  <= slot_q + 1'b1;
						state_q <= S_SLOT;
					end
				end
				S_EMIT: begin
					// k_q addresses decoded list; registered RAM data is ready in the cycle after k settles
					if (out_free) begin
						if (k_q == total_q) begin
							state_q <= S_SUM;
						end else if (hit_q) begin
							out_valid <= 1'b1;
							out_data  <= '{KIND_PKT, dec_rdata, from_q[k_q[SlotW-1:0]], '0, 1'b0};
							k_q       <= k_q + 1'b1;
							hit_q     <= 1'b0;
						end else begin
							hit_q <= 1'b1;
						end
					end
				end
				S_SUM: begin
					if (ovf_q[slot_q] || fill_cur > FillW'(1)) begin
						cnt_q <= cnt_q + 1'b1;
					end
					fill_q[slot_q] <= '0;
					ovf_q[slot_q]  <= 1'b0;
					if (slot_q == SlotW'(NumSlots - 1)) begin
						state_q <= S_CLR;
					end else begin
						slot_q <= slot_q + 1'b1;
					end
				end
				S_CLR: begin
					if (out_free) begin
						out_valid <= 1'b1;
						out_data  <= '{KIND_SUM, 16'd0, 5'd0, 6'(cnt_q), 1'b1};
						total_q   <= '0;
						slot_q    <= '0;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== sv/crdsa_ram.sv =====
// ----------------------------------------------------------------------------
// crdsa_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module crdsa_ram #(
	parameter int Width = 16,
	parameter int Depth = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== sv/crdsa_checker.sv =====
// ----------------------------------------------------------------------------
// crdsa_checker
// Port-level checks on the interference canceller, bound into the canceller module.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module crdsa_checker
	import crdsa_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      in_valid,
	input wire logic      in_ready,
	input wire in_item_t  in_data,
	input wire logic      out_valid,
	input wire logic      out_ready,
	input wire out_item_t out_data
);
	`CHK_IMPLIES(a_sum_last, clk, arst_n, out_valid, (out_data.kind == out_data.last))
	`CHK_IMPLIES(a_pkt_zero, clk, arst_n, out_valid && out_data.kind == KIND_PKT,
		out_data.collision_count == '0)
	`CHK_IMPLIES(a_no_accept_busy, clk, arst_n, in_ready, !out_valid)
	`CHK_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))
endmodule

bind crdsa_interference_cancel crdsa_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.in_data(in_data), .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Frame-level check of the interference canceller. Directed frames cover the
// empty frame, single replicas, slot overflow, duplicate ids and cancellation
// chains; random frames follow. Every decoded id and frame summary is
// compared against a cycle-free model of the sweep decoder.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top;
	import crdsa_pkg::*;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_data;

	crdsa_interference_cancel i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	localparam int CycleLimit = 3000000;

	typedef struct {
		in_item_t  item;
		logic      typed;
		out_item_t res;
	} stim_row_t;

	logic [15:0] slot_ids [NumSlots][SlotCapacity];
	int          slot_cnt [NumSlots];
	logic        slot_full_hit [NumSlots];
	out_item_t   pending_results [$];
	int          mismatch_count;
	int          cycle_count;
	logic        in_idle_ok;
	logic        out_idle_ok;
	logic        hold_off;
	logic        done;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic out_item_t summary_item(int n);
		out_item_t r;
		r = '0;
		r.kind = KIND_SUM;
		r.collision_count = 6'(n);
		r.last = 1'b1;
		return r;
	endfunction

	// frame decoder: sweep slots until a pass decodes nothing
	task automatic decode_frame();
		logic [15:0] ids [$];
		logic        progress;
		int          w;
		int          coll;
		logic        seen;
		out_item_t   r;
		do begin
			progress = 1'b0;
			for (int s = 0; s < NumSlots; s++) begin
				if (slot_full_hit[s] || slot_cnt[s] == 0)
					continue;
				w = 0;
				for (int k = 0; k < slot_cnt[s]; k++) begin
					seen = 1'b0;
					foreach (ids[j])
						if (ids[j] == slot_ids[s][k])
							seen = 1'b1;
					if (!seen) begin
						slot_ids[s][w] = slot_ids[s][k];
						w++;
					end
				end
				slot_cnt[s] = w;
				if (w == 1 && ids.size() < NumSlots) begin
					ids = {ids, slot_ids[s][0]};
					r = '0;
					r.kind = KIND_PKT;
					r.packet_id_res = slot_ids[s][0];
					r.decoded_slot = 5'(s);
					pending_results = {pending_results, r};
					progress = 1'b1;
				end
			end
		end while (progress);
		coll = 0;
		for (int s = 0; s < NumSlots; s++) begin
			if (slot_full_hit[s] || slot_cnt[s] > 1)
				coll++;
			slot_cnt[s] = 0;
			slot_full_hit[s] = 1'b0;
		end
		pending_results = {pending_results, summary_item(coll)};
	endtask

	task automatic predict(in_item_t it);
		if (it.operation == OP_ADD) begin
			if (slot_cnt[it.slot_index] < SlotCapacity) begin
				slot_ids[it.slot_index][slot_cnt[it.slot_index]] = it.packet_id;
				slot_cnt[it.slot_index]++;
			end else begin
				slot_full_hit[it.slot_index] = 1'b1;
			end
		end else begin
			decode_frame();
		end
	endtask

	task automatic send(in_item_t it);
		while (in_idle_ok && ($urandom_range(99) < 26)) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do
			@(posedge clk);
		while (!in_ready);
		predict(it);
	endtask

	function automatic in_item_t mk(logic op, int s, int id);
		in_item_t it;
		it.operation = op;
		it.slot_index = 5'(s);
		it.packet_id = 16'(id);
		return it;
	endfunction

	// output checker
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result %p", out_data);
			end else begin
				if (out_data !== pending_results[0]) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: expected %p got %p",
							pending_results[0], out_data);
				end
				void'(pending_results.pop_front());
			end
		end
	end

	// receiver
	always @(posedge clk) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else if (hold_off)
			out_ready <= 1'b0;
		else
			out_ready <= !(out_idle_ok && ($urandom_range(99) < 26));
	end

	// long receiver hold-off so the block backs up
	initial begin
		hold_off = 1'b0;
		wait (cycle_count == 2000);
		hold_off = 1'b1;
		repeat (400) @(posedge clk);
		hold_off = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit && !done) begin
			$display("** crdsa_interference_cancel: FAILED **");
			$finish;
		end
	end

	initial begin
		stim_row_t rows [$];
		stim_row_t row;
		int        nfr;
		int        nrep;
		int        base;
		logic [15:0] pool [$];
		cycle_count = 0;
		mismatch_count = 0;
		done = 1'b0;
		in_idle_ok = 1'b1;
		out_idle_ok = 1'b1;
		in_valid = 1'b0;
		in_data = '0;
		arst_n = 1'b0;
		for (int s = 0; s < NumSlots; s++) begin
			slot_cnt[s] = 0;
			slot_full_hit[s] = 1'b0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table: empty frame, extremes, overflow, duplicates, chain
		row.typed = 1'b1; row.item = mk(OP_EOF, 31, 16'hffff); row.res = summary_item(0);
		rows = {rows, row};
		row.typed = 1'b0;
		row.item = mk(OP_ADD, 0, 0); rows = {rows, row};
		row.item = mk(OP_ADD, 31, 16'hffff); rows = {rows, row};
		for (int k = 0; k < 9; k++) begin
			row.item = mk(OP_ADD, 5, k + 1); rows = {rows, row};
		end
		row.item = mk(OP_ADD, 7, 16'h5555); rows = {rows, row};
		row.item = mk(OP_ADD, 7, 16'h5555); rows = {rows, row};
		row.item = mk(OP_ADD, 9, 16'haaaa); rows = {rows, row};
		row.item = mk(OP_ADD, 10, 16'haaaa); rows = {rows, row};
		row.item = mk(OP_ADD, 10, 16'h1234); rows = {rows, row};
		row.item = mk(OP_ADD, 11, 16'h1234); rows = {rows, row};
		row.item = mk(OP_ADD, 11, 16'h4321); rows = {rows, row};
		row.item = mk(OP_ADD, 3, 16'h4321); rows = {rows, row};
		row.item = mk(OP_ADD, 3, 16'h0f0f); rows = {rows, row};
		row.item = mk(OP_EOF, 0, 0); rows = {rows, row};

		foreach (rows[i]) begin
			if (rows[i].typed) begin
				send(rows[i].item);
				pending_results[pending_results.size() - 1] = rows[i].res;
			end else begin
				send(rows[i].item);
			end
		end

		// random frames of paired replicas
		nfr = 0;
		while (nfr < 10) begin
			if (nfr >= 4 && nfr < 8)
				in_idle_ok = 1'b0;
			else
				in_idle_ok = 1'b1;
			out_idle_ok = !(nfr >= 4 && nfr < 8);
			pool.delete();
			nrep = $urandom_range(1, 8);
			for (int p = 0; p < nrep; p++)
				pool = {pool, 16'($urandom())};
			base = $urandom_range(0, 3);
			for (int r = 0; r < 2 * nrep; r++) begin
				if ($urandom_range(9) < 8)
					send(mk(OP_ADD, $urandom_range(0, 31) & ~(base & 0),
						pool[$urandom_range(0, nrep - 1)]));
				else
					send(mk(OP_ADD, $urandom_range(0, 31), $urandom()));
			end
			if ($urandom_range(9) == 0)
				for (int k = 0; k < 9; k++)
					send(mk(OP_ADD, 1, $urandom()));
			send(mk(OP_EOF, $urandom_range(0, 31), $urandom()));
			nfr++;
		end
		in_valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		done = 1'b1;
		if (mismatch_count == 0 && pending_results.size() == 0)
			$display("** crdsa_interference_cancel: PASSED **");
		else
			$display("** crdsa_interference_cancel: FAILED **");
		$finish;
	end
endmodule
`default_nettype wire
